[rtl/psc_pkg.sv]
package psc_pkg;

	// Position counter width and its saturation value
	localparam int unsigned POS_W = 13;
	localparam logic [POS_W-1:0] POS_MAX = 13'd8191;

	// Only the first TEXT_SCAN_LIMIT bytes are checked for control codes
	localparam logic [POS_W-1:0] TEXT_SCAN_LIMIT = 13'd4096;

	// Cartridge logo window
	localparam logic [POS_W-1:0] LOGO_OFFSET = 13'h104;
	localparam logic [POS_W-1:0] LOGO_END    = 13'h134;
	localparam int unsigned LOGO_IDX_W = 6;

	// Signature bytes
	localparam logic [7:0] CH_P = 8'h50;
	localparam logic [7:0] CH_K = 8'h4B;
	localparam logic [7:0] CH_M = 8'h4D;
	localparam logic [7:0] CH_Z = 8'h5A;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB = 8'h09;
	localparam logic [7:0] CH_LF  = 8'h0A;
	localparam logic [7:0] CH_CR  = 8'h0D;

	// Classification codes
	typedef enum logic [2:0] {
		REASON_UNKNOWN = 3'd0,
		REASON_ARCHIVE = 3'd1,
		REASON_EXEC    = 3'd2,
		REASON_CART    = 3'd3,
		REASON_TEXT    = 3'd4
	} reason_t;

	// Cartridge logo ROM, 48 entries
	function automatic logic [7:0] logo_rom(input logic [LOGO_IDX_W-1:0] idx);
		logic [7:0] v;
		case (idx)
			6'd0:  v = 8'hCE; 6'd1:  v = 8'hED; 6'd2:  v = 8'h66; 6'd3:  v = 8'h66;
			6'd4:  v = 8'hCC; 6'd5:  v = 8'h0D; 6'd6:  v = 8'h00; 6'd7:  v = 8'h0B;
			6'd8:  v = 8'h03; 6'd9:  v = 8'h73; 6'd10: v = 8'h00; 6'd11: v = 8'h83;
			6'd12: v = 8'h00; 6'd13: v = 8'h0C; 6'd14: v = 8'h00; 6'd15: v = 8'h0D;
			6'd16: v = 8'h00; 6'd17: v = 8'h08; 6'd18: v = 8'h11; 6'd19: v = 8'h1F;
			6'd20: v = 8'h88; 6'd21: v = 8'h89; 6'd22: v = 8'h00; 6'd23: v = 8'h0E;
			6'd24: v = 8'hDC; 6'd25: v = 8'hCC; 6'd26: v = 8'h6E; 6'd27: v = 8'hE6;
			6'd28: v = 8'hDD; 6'd29: v = 8'hDD; 6'd30: v = 8'hD9; 6'd31: v = 8'h99;
			6'd32: v = 8'hBB; 6'd33: v = 8'hBB; 6'd34: v = 8'h67; 6'd35: v = 8'h63;
			6'd36: v = 8'h6E; 6'd37: v = 8'h0E; 6'd38: v = 8'hEC; 6'd39: v = 8'hCC;
			6'd40: v = 8'hDD; 6'd41: v = 8'hDC; 6'd42: v = 8'h99; 6'd43: v = 8'h9F;
			6'd44: v = 8'hBB; 6'd45: v = 8'hB9; 6'd46: v = 8'h33; 6'd47: v = 8'h3E;
			default: v = 8'h00;
		endcase
		return v;
	endfunction

endpackage

[rtl/payload_signature_classifier.sv]
// Payload signature classifier. Bytes of a payload arrive one per item, in
// order; the item flagged last_byte (or an item flagged empty_payload) yields one
// reason code, checked in priority order: zip archive ("PK" plus 03 04, 05 06 or
// 07 08), executable ("MZ"), cartridge image (48-byte logo at offset 0x104, at
// least 308 bytes), text (no NUL or control byte other than tab/LF/CR in the
// first 4096 bytes), else unknown. One item is accepted every clock cycle
// unless a final item waits on a result register that is not read; the work
// per byte is a single compare against one logo ROM entry plus flag updates
// between the input register and the result register. Bytes past 8191 still
// count toward the payload but the position counter saturates there.
module payload_signature_classifier
	import psc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       item_valid,
	output logic       item_ready,
	input  logic [7:0] payload_byte,
	input  logic       last_byte,
	input  logic       empty_payload,
	output logic       result_valid,
	input  logic       result_ready,
	output logic [2:0] reason
);

	// Input stage
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;
	logic       empty_s1;

	// Per-payload state
	logic [POS_W-1:0] byte_position_q;
	logic [31:0]      leading_bytes_q;
	logic             logo_matches_q;
	logic             text_clean_q;

	// Result register
	logic    result_valid_q;
	reason_t reason_q;

	// Combinational results of stage 1
	logic [POS_W-1:0]      pos_next;
	logic [31:0]           lead_next;
	logic                  logo_next;
	logic                  text_next;
	logic [POS_W-1:0]      logo_off;
	logic [LOGO_IDX_W-1:0] logo_idx;
	logic                  forbidden;
	logic                  produces;
	logic                  advance;
	logic                  is_archive;
	logic                  is_exec;
	reason_t               reason_c;

	// Byte update for the item in stage 1
	always_comb begin
		lead_next = leading_bytes_q;
		if (byte_position_q < POS_W'(4)) begin
			case (byte_position_q[1:0])
				2'd0:    lead_next[7:0]   = byte_s1;
				2'd1:    lead_next[15:8]  = byte_s1;
				2'd2:    lead_next[23:16] = byte_s1;
				default: lead_next[31:24] = byte_s1;
			endcase
		end

		logo_off = byte_position_q - LOGO_OFFSET;
		logo_idx = logo_off[LOGO_IDX_W-1:0];
		logo_next = logo_matches_q;
		if (byte_position_q >= LOGO_OFFSET && byte_position_q < LOGO_END &&
				byte_s1 != logo_rom(logo_idx)) begin
			logo_next = 1'b0;
		end

		forbidden = (byte_s1 < CH_SPACE) &&
			!(byte_s1 inside {CH_TAB, CH_LF, CH_CR});
		text_next = text_clean_q;
		if (byte_position_q < TEXT_SCAN_LIMIT && forbidden) begin
			text_next = 1'b0;
		end

		pos_next = (byte_position_q == POS_MAX) ? byte_position_q
			: byte_position_q + POS_W'(1);
	end

	// Classification on the final byte (length = position + 1)
	always_comb begin
		is_archive = (byte_position_q >= POS_W'(3)) &&
			lead_next[7:0] == CH_P && lead_next[15:8] == CH_K &&
			((lead_next[23:16] == 8'h03 && lead_next[31:24] == 8'h04) ||
			 (lead_next[23:16] == 8'h05 && lead_next[31:24] == 8'h06) ||
			 (lead_next[23:16] == 8'h07 && lead_next[31:24] == 8'h08));
		is_exec = (byte_position_q >= POS_W'(1)) &&
			lead_next[7:0] == CH_M && lead_next[15:8] == CH_Z;

		if (empty_s1) begin
			reason_c = REASON_TEXT;
		end else if (is_archive) begin
			reason_c = REASON_ARCHIVE;
		end else if (is_exec) begin
			reason_c = REASON_EXEC;
		end else if (byte_position_q >= LOGO_END - POS_W'(1) && logo_next) begin
			reason_c = REASON_CART;
		end else if (text_next) begin
			reason_c = REASON_TEXT;
		end else begin
			reason_c = REASON_UNKNOWN;
		end
	end

	// Handshake: stage 1 moves on unless its result is blocked
	assign produces   = empty_s1 || last_s1;
	assign advance    = valid_s1 && (!produces || !result_valid_q || result_ready);
	assign item_ready = !valid_s1 || advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_ready && item_valid) begin
			byte_s1  <= payload_byte;
			last_s1  <= last_byte;
			empty_s1 <= empty_payload;
		end
	end

	// Payload state; cleared at the end of every payload
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_position_q <= '0;
			leading_bytes_q <= '0;
			logo_matches_q  <= 1'b1;
			text_clean_q    <= 1'b1;
		end else if (advance) begin
			if (produces) begin
				byte_position_q <= '0;
				leading_bytes_q <= '0;
				logo_matches_q  <= 1'b1;
				text_clean_q    <= 1'b1;
			end else begin
				byte_position_q <= pos_next;
				leading_bytes_q <= lead_next;
				logo_matches_q  <= logo_next;
				text_clean_q    <= text_next;
			end
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (advance && produces) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && produces) begin
			reason_q <= reason_c;
		end
	end

	assign result_valid = result_valid_q;
	assign reason       = reason_q;

endmodule

[bench/tb_top.sv]
module tb_top;
	import psc_pkg::*;

	// One byte item as the sender presents it; drain holds the item back until
	// every outstanding classification has come out.
	typedef struct {
		logic [7:0] data;
		logic       is_last;
		logic       is_empty;
		bit         drain;
	} sniff_item_t;

	// Second half of a zip signature, bytes 2 and 3 as one little-endian word
	localparam logic [15:0] ZIP_LOCAL   = 16'h0403;
	localparam logic [15:0] ZIP_CENTRAL = 16'h0605;
	localparam logic [15:0] ZIP_SPAN    = 16'h0807;

	// Cartridge logo, byte 0 in the top bits
	localparam logic [383:0] CART_LOGO = {
		8'hCE, 8'hED, 8'h66, 8'h66, 8'hCC, 8'h0D, 8'h00, 8'h0B,
		8'h03, 8'h73, 8'h00, 8'h83, 8'h00, 8'h0C, 8'h00, 8'h0D,
		8'h00, 8'h08, 8'h11, 8'h1F, 8'h88, 8'h89, 8'h00, 8'h0E,
		8'hDC, 8'hCC, 8'h6E, 8'hE6, 8'hDD, 8'hDD, 8'hD9, 8'h99,
		8'hBB, 8'hBB, 8'h67, 8'h63, 8'h6E, 8'h0E, 8'hEC, 8'hCC,
		8'hDD, 8'hDC, 8'h99, 8'h9F, 8'hBB, 8'hB9, 8'h33, 8'h3E
	};
	localparam int LOGO_BYTES = 48;

	logic       clk;
	logic       arst_n = 1'b0;
	logic       item_valid = 1'b0;
	logic       item_ready;
	logic [7:0] payload_byte = 8'h00;
	logic       last_byte = 1'b0;
	logic       empty_payload = 1'b0;
	logic       result_valid;
	logic       result_ready = 1'b0;
	logic [2:0] reason;

	payload_signature_classifier DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.payload_byte (payload_byte),
		.last_byte    (last_byte),
		.empty_payload(empty_payload),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.reason       (reason)
	);

	sniff_item_t byte_stream[$];
	reason_t     expected_reasons[$];
	logic [7:0]  pl[$];
	int          mismatches = 0;

	// Shadow of the classifier state
	logic [12:0] scan_pos;
	logic [31:0] lead_word;
	bit          logo_seen;
	bit          text_seen;

	bit in_fire = 1'b0;
	bit out_fire = 1'b0;
	int send_gap = 0;
	int sink_hold = 0;
	bit src_burst = 1'b0;
	bit sink_burst = 1'b0;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#40_000_000;
		$display("TB_ERROR");
		$finish;
	end

	function automatic logic [7:0] logo_at(input int idx);
		return CART_LOGO[383 - 8*idx -: 8];
	endfunction

	function automatic void clear_sniff_state();
		scan_pos  = '0;
		lead_word = '0;
		logo_seen = 1'b1;
		text_seen = 1'b1;
	endfunction

	// Advance the shadow state by one item; returns 1 when a code is due
	function automatic bit sniff_byte(input sniff_item_t it, output reason_t verdict);
		int unsigned p;
		int unsigned len;
		verdict = REASON_TEXT;
		if (it.is_empty) begin
			clear_sniff_state();
			return 1'b1;
		end
		p = scan_pos;
		if (p < 4)
			lead_word[8*p +: 8] = it.data;
		if (p >= LOGO_OFFSET && p < LOGO_END && it.data != logo_at(p - LOGO_OFFSET))
			logo_seen = 1'b0;
		if (p < TEXT_SCAN_LIMIT && it.data < CH_SPACE && it.data != CH_TAB &&
				it.data != CH_LF && it.data != CH_CR)
			text_seen = 1'b0;
		len = p + 1;
		if (p < POS_MAX)
			scan_pos = scan_pos + 13'd1;
		if (!it.is_last)
			return 1'b0;
		// priority: archive, executable, cartridge, text
		if (len >= 4 && lead_word[15:0] == {CH_K, CH_P} &&
				(lead_word[31:16] == ZIP_LOCAL || lead_word[31:16] == ZIP_CENTRAL ||
				 lead_word[31:16] == ZIP_SPAN))
			verdict = REASON_ARCHIVE;
		else if (len >= 2 && lead_word[15:0] == {CH_Z, CH_M})
			verdict = REASON_EXEC;
		else if (len >= LOGO_END && logo_seen)
			verdict = REASON_CART;
		else if (text_seen)
			verdict = REASON_TEXT;
		else
			verdict = REASON_UNKNOWN;
		clear_sniff_state();
		return 1'b1;
	endfunction

	task automatic note_mismatch(input string what);
		$display("MISMATCH @%0t: %s", $time, what);
		mismatches++;
	endtask

	// Payload builders
	function automatic logic [7:0] clean_byte();
		case ($urandom_range(0, 11))
			0: return CH_TAB;
			1: return CH_LF;
			2: return CH_CR;
			default: return 8'($urandom_range(32, 255));
		endcase
	endfunction

	task automatic fill_text(input int n);
		repeat (n) pl.push_back(clean_byte());
	endtask

	task automatic fill_any(input int n);
		repeat (n) pl.push_back(8'($urandom_range(0, 255)));
	endtask

	// Pad up to the logo window and lay the logo down, optionally with one bad byte
	task automatic put_logo(input bit corrupt);
		int idx;
		while (pl.size() < LOGO_OFFSET)
			pl.push_back(8'($urandom_range(0, 255)));
		for (int i = 0; i < LOGO_BYTES; i++)
			pl.push_back(logo_at(i));
		if (corrupt) begin
			idx = $urandom_range(0, LOGO_BYTES - 1);
			pl[LOGO_OFFSET + idx] = pl[LOGO_OFFSET + idx] ^ 8'($urandom_range(1, 255));
		end
	endtask

	task automatic emit_empty(input bit drain);
		sniff_item_t it;
		it.data     = 8'($urandom_range(0, 255));
		it.is_last  = 1'($urandom_range(0, 1));
		it.is_empty = 1'b1;
		it.drain    = drain;
		byte_stream.push_back(it);
	endtask

	// Queue the built payload; an aborted one ends in an empty item instead of last
	task automatic emit_payload(input bit drain, input bit abort);
		sniff_item_t it;
		foreach (pl[i]) begin
			it.data     = pl[i];
			it.is_last  = !abort && (i == pl.size() - 1);
			it.is_empty = 1'b0;
			it.drain    = drain && (i == 0);
			byte_stream.push_back(it);
		end
		if (abort)
			emit_empty(1'b0);
		pl.delete();
	endtask

	// Sender: presents the next item at the falling edge after a random gap
	always @(negedge clk) begin
		if (arst_n) begin
			if (in_fire || !item_valid) begin
				if (in_fire) begin
					if ($urandom_range(0, 63) == 0)
						src_burst = !src_burst;
					send_gap = src_burst ? 0 : $urandom_range(0, 9);
				end
				if (send_gap > 0) begin
					send_gap--;
					item_valid <= 1'b0;
				end else if (byte_stream.size() == 0) begin
					item_valid <= 1'b0;
				end else if (byte_stream[0].drain && expected_reasons.size() != 0) begin
					item_valid <= 1'b0;
				end else begin
					item_valid    <= 1'b1;
					payload_byte  <= byte_stream[0].data;
					last_byte     <= byte_stream[0].is_last;
					empty_payload <= byte_stream[0].is_empty;
					void'(byte_stream.pop_front());
				end
			end
		end
	end

	// Receiver: random stall after each accepted result
	always @(negedge clk) begin
		if (arst_n) begin
			if (out_fire) begin
				if ($urandom_range(0, 63) == 0)
					sink_burst = !sink_burst;
				sink_hold = sink_burst ? 0 : $urandom_range(0, 9);
			end
			if (sink_hold > 0) begin
				sink_hold--;
				result_ready <= 1'b0;
			end else begin
				result_ready <= 1'b1;
			end
		end
	end

	// Monitor: check results first, then predict from the accepted item
	always @(posedge clk) begin
		sniff_item_t it;
		reason_t     verdict;
		reason_t     want;
		if (arst_n) begin
			if (result_valid && result_ready) begin
				if (expected_reasons.size() == 0) begin
					note_mismatch($sformatf("unexpected result reason=%0d", reason));
				end else begin
					want = expected_reasons.pop_front();
					if (reason !== want)
						note_mismatch($sformatf("reason=%0d, expected %0d (%s)",
							reason, want, want.name()));
				end
			end
			if (item_valid && item_ready) begin
				it.data     = payload_byte;
				it.is_last  = last_byte;
				it.is_empty = empty_payload;
				it.drain    = 1'b0;
				if (sniff_byte(it, verdict))
					expected_reasons.push_back(verdict);
			end
		end
		in_fire  <= arst_n && item_valid && item_ready;
		out_fire <= arst_n && result_valid && result_ready;
	end

	initial begin
		int base;
		int kind;
		int cut;
		clear_sniff_state();

		// Directed: empty, single bytes, every signature and its near misses
		emit_empty(1'b1);
		pl = '{8'h00};                         emit_payload(1'b0, 1'b0);
		pl = '{8'hFF};                         emit_payload(1'b0, 1'b0);
		pl = '{CH_P, CH_K, 8'h03, 8'h04};      emit_payload(1'b0, 1'b0);
		pl = '{CH_P, CH_K, 8'h05, 8'h06, 8'h41}; emit_payload(1'b0, 1'b0);
		pl = '{CH_P, CH_K, 8'h07, 8'h08};      emit_payload(1'b0, 1'b0);
		pl = '{CH_P, CH_K, 8'h03, 8'h05};      emit_payload(1'b0, 1'b0);
		pl = '{CH_P, CH_K, 8'h03};             emit_payload(1'b0, 1'b0);
		pl = '{CH_M, CH_Z};                    emit_payload(1'b0, 1'b0);
		pl = '{CH_M};                          emit_payload(1'b0, 1'b0);
		pl = '{CH_M, CH_Z, 8'h00, 8'h00};      emit_payload(1'b0, 1'b0);
		pl = '{CH_TAB, CH_LF, CH_CR, CH_SPACE}; emit_payload(1'b0, 1'b0);
		pl = '{8'h1F};                         emit_payload(1'b0, 1'b0);
		pl = '{8'h08, 8'h0B, 8'h0C, 8'h0E};    emit_payload(1'b0, 1'b0);
		// partial archive dropped by an empty item, then a fresh payload
		pl = '{CH_P, CH_K, 8'h03};             emit_payload(1'b0, 1'b1);
		pl = '{CH_M, CH_Z};                    emit_payload(1'b1, 1'b0);

		// Cartridge: exact, bad byte, one byte short, shadowed by archive and exe
		put_logo(1'b0);                        emit_payload(1'b0, 1'b0);
		put_logo(1'b1);                        emit_payload(1'b0, 1'b0);
		put_logo(1'b0); void'(pl.pop_back());  emit_payload(1'b0, 1'b0);
		pl = '{CH_P, CH_K, 8'h07, 8'h08}; put_logo(1'b0); emit_payload(1'b0, 1'b0);
		pl = '{CH_M, CH_Z}; put_logo(1'b0); fill_any(3); emit_payload(1'b0, 1'b0);

		// Text scan limit: last scanned byte is bad, then first unscanned one
		fill_text(TEXT_SCAN_LIMIT - 1); pl.push_back(8'h01); emit_payload(1'b0, 1'b0);
		fill_text(TEXT_SCAN_LIMIT); pl.push_back(8'h00); emit_payload(1'b0, 1'b0);
		// Position counter saturation with bad bytes beyond it
		fill_text(POS_MAX); pl.push_back(8'h00); pl.push_back(clean_byte());
		pl.push_back(8'h00); pl.push_back(CH_SPACE);
		emit_payload(1'b1, 1'b0);

		// Random payloads: signatures with random content, text, random bytes, empty and aborted ones
		base = byte_stream.size();
		while (byte_stream.size() < base + 1700) begin
			kind = $urandom_range(0, 99);
			if (kind < 20) begin
				pl = '{CH_P, CH_K};
				case ($urandom_range(0, 3))
					0: begin pl.push_back(8'h03); pl.push_back(8'h04); end
					1: begin pl.push_back(8'h05); pl.push_back(8'h06); end
					2: begin pl.push_back(8'h07); pl.push_back(8'h08); end
					default: fill_any(2);
				endcase
				if ($urandom_range(0, 1)) fill_any($urandom_range(0, 6));
				else fill_text($urandom_range(0, 6));
				if ($urandom_range(0, 4) == 0) begin
					cut = $urandom_range(1, 3);
					while (pl.size() > cut) void'(pl.pop_back());
				end
			end else if (kind < 35) begin
				pl = '{CH_M};
				if ($urandom_range(0, 3) != 0) pl.push_back(CH_Z);
				else fill_any(1);
				if ($urandom_range(0, 1)) fill_any($urandom_range(0, 6));
				else fill_text($urandom_range(0, 6));
			end else if (kind < 37) begin
				put_logo($urandom_range(0, 2) == 0);
				fill_any($urandom_range(0, 4));
			end else if (kind < 60) begin
				fill_text($urandom_range(1, 16));
			end else if (kind < 85) begin
				fill_any($urandom_range(1, 16));
			end else if (kind < 93) begin
				emit_empty($urandom_range(0, 29) == 0);
			end else begin
				fill_any($urandom_range(1, 5));
				emit_payload(1'b0, 1'b1);
			end
			if (pl.size() != 0)
				emit_payload($urandom_range(0, 29) == 0, 1'b0);
		end

		// Reset, then let the sender drain the stream
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		while (byte_stream.size() != 0 || item_valid)
			@(posedge clk);
		while (expected_reasons.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
